>>> rtl/rtttl_pkg.sv
// rtttl_pkg: shared types, parser codes and lookup functions for the ringtone parser
// used by rtttl_ctrl, rtttl_dp and rtttl_ringtone_note_parser; no dependencies
package rtttl_pkg;

    // parser phases
    localparam logic [3:0] PH_NAME       = 4'd0;
    localparam logic [3:0] PH_HDR_ITEM   = 4'd1;
    localparam logic [3:0] PH_HDR_TAG    = 4'd2;
    localparam logic [3:0] PH_HDR_NUM    = 4'd3;
    localparam logic [3:0] PH_HDR_SKIP   = 4'd4;
    localparam logic [3:0] PH_TOK_START  = 4'd5;
    localparam logic [3:0] PH_TOK_LEN    = 4'd6;
    localparam logic [3:0] PH_TOK_LETTER = 4'd7;
    localparam logic [3:0] PH_TOK_SHARP  = 4'd8;
    localparam logic [3:0] PH_TOK_OCT    = 4'd9;
    localparam logic [3:0] PH_TOK_SKIP   = 4'd10;

    // header tags
    localparam logic [1:0] TAG_NONE = 2'd0;
    localparam logic [1:0] TAG_D    = 2'd1;
    localparam logic [1:0] TAG_O    = 2'd2;
    localparam logic [1:0] TAG_B    = 2'd3;

    localparam logic [15:0] DEFAULT_LEN   = 16'd4;
    localparam logic [2:0]  DEFAULT_OCT   = 3'd6;
    localparam logic [15:0] DEFAULT_BPM   = 16'd63;
    localparam logic [17:0] MS_PER_MINUTE = 18'd60000;
    localparam logic [18:0] MIN_NOTE_MS   = 19'd10;
    localparam logic [3:0]  VOLUME_RESET  = 4'd5;
    localparam int          DIV_STEPS     = 18;
    localparam int          CNT_W         = $clog2(DIV_STEPS + 1);

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic hdr_write;
        logic out_load;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_hdr;
        logic need_note;
        logic need_bare;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // letter to pitch code: 0 rest, 1..7 = c d e f g a b
    function automatic logic [2:0] letter_code(input logic [7:0] c);
        logic [7:0] lc;
        logic [2:0] r;
        lc = (c >= 8'h41 && c <= 8'h5a) ? (c + 8'h20) : c;
        case (lc)
            8'h63:   r = 3'd1;
            8'h64:   r = 3'd2;
            8'h65:   r = 3'd3;
            8'h66:   r = 3'd4;
            8'h67:   r = 3'd5;
            8'h61:   r = 3'd6;
            8'h62:   r = 3'd7;
            8'h68:   r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] semitone_of(input logic [2:0] code);
        logic [3:0] r;
        case (code)
            3'd2:    r = 4'd2;
            3'd3:    r = 4'd4;
            3'd4:    r = 4'd5;
            3'd5:    r = 4'd7;
            3'd6:    r = 4'd9;
            3'd7:    r = 4'd11;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // rounded 12-tet frequencies, octaves 4..7
    function automatic logic [11:0] tone_of(input logic [5:0] idx);
        logic [11:0] r;
        case (idx)
            6'd0:  r = 12'd262;  6'd1:  r = 12'd277;  6'd2:  r = 12'd294;
            6'd3:  r = 12'd311;  6'd4:  r = 12'd330;  6'd5:  r = 12'd349;
            6'd6:  r = 12'd370;  6'd7:  r = 12'd392;  6'd8:  r = 12'd415;
            6'd9:  r = 12'd440;  6'd10: r = 12'd466;  6'd11: r = 12'd494;
            6'd12: r = 12'd523;  6'd13: r = 12'd554;  6'd14: r = 12'd587;
            6'd15: r = 12'd622;  6'd16: r = 12'd659;  6'd17: r = 12'd698;
            6'd18: r = 12'd740;  6'd19: r = 12'd784;  6'd20: r = 12'd831;
            6'd21: r = 12'd880;  6'd22: r = 12'd932;  6'd23: r = 12'd988;
            6'd24: r = 12'd1047; 6'd25: r = 12'd1109; 6'd26: r = 12'd1175;
            6'd27: r = 12'd1245; 6'd28: r = 12'd1319; 6'd29: r = 12'd1397;
            6'd30: r = 12'd1480; 6'd31: r = 12'd1568; 6'd32: r = 12'd1661;
            6'd33: r = 12'd1760; 6'd34: r = 12'd1865; 6'd35: r = 12'd1976;
            6'd36: r = 12'd2093; 6'd37: r = 12'd2217; 6'd38: r = 12'd2349;
            6'd39: r = 12'd2489; 6'd40: r = 12'd2637; 6'd41: r = 12'd2794;
            6'd42: r = 12'd2960; 6'd43: r = 12'd3136; 6'd44: r = 12'd3322;
            6'd45: r = 12'd3520; 6'd46: r = 12'd3729; 6'd47: r = 12'd3951;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

    // volume step to duty, 0 mutes, above ten acts as ten
    function automatic logic [7:0] duty_of(input logic [3:0] v);
        logic [7:0] r;
        case (v)
            4'd0:    r = 8'd0;
            4'd1:    r = 8'd8;
            4'd2:    r = 8'd21;
            4'd3:    r = 8'd34;
            4'd4:    r = 8'd48;
            4'd5:    r = 8'd61;
            4'd6:    r = 8'd74;
            4'd7:    r = 8'd88;
            4'd8:    r = 8'd101;
            4'd9:    r = 8'd114;
            default: r = 8'd128;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/rtttl_ringtone_note_parser.sv
// rtttl_ringtone_note_parser: top level of the ringtone text note parser
// depends on rtttl_pkg, rtttl_ctrl and rtttl_dp

// Takes ringtone text one byte per input beat and returns at most one result per
// byte: a note or rest (frequency, duration, duty) when a note token closes, or
// an end result on the byte flagged last_char, after which the parser restarts.
// A byte that sends nothing leaves the controller idle for the next byte; a bare
// end result goes through S_POST first. The header close and every note run the
// shared restoring divider, 18 quotient bits at one per cycle, and in_ready stays
// low while it runs; after a note, S_POST loads the result register. That load
// waits while an earlier result is still unread; otherwise the next byte is taken
// while the result waits to be read. The user writes volume_level through its own
// port only while the block is idle; the block itself does not enforce this.
module rtttl_ringtone_note_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  volume_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_note,
    output logic        is_rest,
    output logic [11:0] frequency_hz,
    output logic [18:0] duration_ms,
    output logic [7:0]  pwm_duty,
    output logic        tune_end
);
    import rtttl_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rtttl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rtttl_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (char_code),
        .last_char    (last_char),
        .cfg_write    (cfg_valid && cfg_ready),
        .volume_level (volume_level),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .is_note      (is_note),
        .is_rest      (is_rest),
        .frequency_hz (frequency_hz),
        .duration_ms  (duration_ms),
        .pwm_duty     (pwm_duty),
        .tune_end     (tune_end)
    );

    // no new byte while the divider runs
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.div_busy)
        else $error("byte offered while divider busy");

    // a result appears only after a load command
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result without load");

    // whole-note time written only from a finished quotient
    a_hdr_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hdr_write |-> !status.div_busy)
        else $error("header write during division");

endmodule

>>> rtl/rtttl_ctrl.sv
// rtttl_ctrl: sequencing state machine for the ringtone parser
// depends on rtttl_pkg for the command and status structs
module rtttl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rtttl_pkg::dp_status_t status,
    output rtttl_pkg::ctl_cmd_t   cmd
);
    import rtttl_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HDR  = 2'd1;
    localparam logic [1:0] S_NOTE = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    logic [1:0] state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.hdr_write = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (status.need_hdr)
                        state_next = S_HDR;
                    else if (status.need_note)
                        state_next = S_NOTE;
                    else if (status.need_bare)
                        state_next = S_POST;
                end
            end
            S_HDR:
            begin
                if (!status.div_busy)
                begin
                    cmd.hdr_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_NOTE:
            begin
                if (!status.div_busy)
                    state_next = S_POST;
            end
            S_POST:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> rtl/rtttl_dp.sv
// rtttl_dp: character parser registers, shared iterative divider and result register
// depends on rtttl_pkg for codes, tables and the command and status structs
module rtttl_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            char_code,
    input  logic                  last_char,
    input  logic                  cfg_write,
    input  logic [3:0]            volume_level,
    input  rtttl_pkg::ctl_cmd_t   cmd,
    output rtttl_pkg::dp_status_t status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  is_note,
    output logic                  is_rest,
    output logic [11:0]           frequency_hz,
    output logic [18:0]           duration_ms,
    output logic [7:0]            pwm_duty,
    output logic                  tune_end
);
    import rtttl_pkg::*;

    // parser state
    logic [3:0]  phase_reg, phase_next;
    logic [15:0] dlen_reg, dlen_next;
    logic [2:0]  doct_reg, doct_next;
    logic [15:0] tempo_reg, tempo_next;
    logic [17:0] whole_reg;
    logic [1:0]  tag_reg, tag_next;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [2:0]  let_reg, let_next;
    logic        sharp_reg, sharp_next;
    logic [15:0] toct_reg, toct_next;
    logic        dot_reg, dot_next;
    logic [3:0]  vol_reg;

    // captured note
    logic [2:0]  p_let_reg;
    logic        p_sharp_reg, p_dot_reg, p_note_reg, p_end_reg;
    logic [1:0]  p_oct_reg;

    // divider
    logic [CNT_W-1:0] cnt_reg;
    logic [17:0]      quo_reg;
    logic [15:0]      rem_reg, dvs_reg;
    logic [16:0]      trial;
    logic [16:0]      diff;

    // result register
    logic        ov_reg, note_o_reg, rest_o_reg, end_o_reg;
    logic [11:0] freq_o_reg;
    logic [18:0] ms_o_reg;
    logic [7:0]  duty_o_reg;

    // parse combinational
    logic        is_dig, after_let, emit, end_hdr, last_note;
    logic [3:0]  dig;
    logic [7:0]  lc;
    logic [15:0] cap_len, cap_oct16;
    logic [1:0]  cap_oct;

    always_comb
    begin
        is_dig     = (char_code >= 8'h30) && (char_code <= 8'h39);
        dig        = char_code[3:0];
        lc         = (char_code >= 8'h41 && char_code <= 8'h5a) ? (char_code + 8'h20)
                                                               : char_code;
        phase_next = phase_reg;
        dlen_next  = dlen_reg;
        doct_next  = doct_reg;
        tempo_next = tempo_reg;
        tag_next   = tag_reg;
        acc_next   = acc_reg;
        tlen_next  = tlen_reg;
        let_next   = let_reg;
        sharp_next = sharp_reg;
        toct_next  = toct_reg;
        dot_next   = dot_reg;
        after_let  = 1'b0;
        emit       = 1'b0;
        end_hdr    = 1'b0;
        case (phase_reg)
            PH_NAME:
            begin
                if (char_code == 8'h3a)
                    phase_next = PH_HDR_ITEM;
            end
            PH_HDR_ITEM:
            begin
                if (char_code == 8'h3a)
                    end_hdr = 1'b1;
                else if (char_code == 8'h20 || char_code == 8'h2c)
                    phase_next = phase_reg;
                else if (lc == 8'h64)
                begin
                    tag_next   = TAG_D;
                    phase_next = PH_HDR_TAG;
                end
                else if (lc == 8'h6f)
                begin
                    tag_next   = TAG_O;
                    phase_next = PH_HDR_TAG;
                end
                else if (lc == 8'h62)
                begin
                    tag_next   = TAG_B;
                    phase_next = PH_HDR_TAG;
                end
                else
                    phase_next = PH_HDR_SKIP;
            end
            PH_HDR_TAG:
            begin
                if (char_code == 8'h3d)
                begin
                    acc_next   = 16'd0;
                    phase_next = PH_HDR_NUM;
                end
                else if (char_code == 8'h3a)
                    end_hdr = 1'b1;
                else if (char_code == 8'h2c)
                    phase_next = PH_HDR_ITEM;
                else
                    phase_next = PH_HDR_SKIP;
            end
            PH_HDR_NUM:
            begin
                if (is_dig)
                    acc_next = (acc_reg << 3) + (acc_reg << 1) + {12'd0, dig};
                else
                begin
                    if (tag_reg == TAG_D && acc_reg != 16'd0)
                        dlen_next = acc_reg;
                    if (tag_reg == TAG_O && acc_reg >= 16'd4 && acc_reg <= 16'd7)
                        doct_next = acc_reg[2:0];
                    if (tag_reg == TAG_B && acc_reg != 16'd0)
                        tempo_next = acc_reg;
                    if (char_code == 8'h3a)
                        end_hdr = 1'b1;
                    else if (char_code == 8'h2c)
                        phase_next = PH_HDR_ITEM;
                    else
                        phase_next = PH_HDR_SKIP;
                end
            end
            PH_HDR_SKIP:
            begin
                if (char_code == 8'h3a)
                    end_hdr = 1'b1;
                else if (char_code == 8'h2c)
                    phase_next = PH_HDR_ITEM;
            end
            PH_TOK_START:
            begin
                if (char_code == 8'h20 || char_code == 8'h2c)
                    phase_next = phase_reg;
                else if (is_dig)
                begin
                    tlen_next  = {12'd0, dig};
                    phase_next = PH_TOK_LEN;
                end
                else
                begin
                    let_next   = letter_code(char_code);
                    phase_next = PH_TOK_LETTER;
                end
            end
            PH_TOK_LEN:
            begin
                if (is_dig)
                    tlen_next = (tlen_reg << 3) + (tlen_reg << 1) + {12'd0, dig};
                else
                begin
                    let_next   = letter_code(char_code);
                    phase_next = PH_TOK_LETTER;
                end
            end
            PH_TOK_LETTER:
            begin
                if (char_code == 8'h23)
                begin
                    if (let_reg != 3'd0)
                        sharp_next = 1'b1;
                    phase_next = PH_TOK_SHARP;
                end
                else
                    after_let = 1'b1;
            end
            PH_TOK_SHARP: after_let = 1'b1;
            PH_TOK_OCT:
            begin
                if (is_dig)
                    toct_next = (toct_reg << 3) + (toct_reg << 1) + {12'd0, dig};
                else
                    after_let = 1'b1;
            end
            PH_TOK_SKIP:
            begin
                if (char_code == 8'h2c)
                    emit = 1'b1;
            end
            default: phase_next = PH_NAME;
        endcase

        // shared tail after letter, sharp or octave digits
        if (after_let)
        begin
            if (is_dig)
            begin
                toct_next  = {12'd0, dig};
                phase_next = PH_TOK_OCT;
            end
            else if (char_code == 8'h2e)
            begin
                dot_next   = 1'b1;
                phase_next = PH_TOK_SKIP;
            end
            else if (char_code == 8'h2c)
                emit = 1'b1;
            else
                phase_next = PH_TOK_SKIP;
        end

        // header close moves to the note section
        if (end_hdr)
            phase_next = PH_TOK_START;

        last_note = last_char && !emit && (phase_next inside {[PH_TOK_LETTER:PH_TOK_SKIP]});

        // resolved length and octave of the note being sent
        cap_len   = (tlen_next != 16'd0) ? tlen_next : dlen_next;
        cap_oct16 = (toct_next != 16'd0) ? toct_next : {13'd0, doct_next};
        if (cap_oct16 < 16'd4)
            cap_oct = 2'd0;
        else if (cap_oct16 > 16'd7)
            cap_oct = 2'd3;
        else
            cap_oct = cap_oct16[1:0];

        // a sent note or header close clears the token
        if (emit || end_hdr)
        begin
            tlen_next  = 16'd0;
            let_next   = 3'd0;
            sharp_next = 1'b0;
            toct_next  = 16'd0;
            dot_next   = 1'b0;
        end
        if (emit)
            phase_next = PH_TOK_START;

        // last character restarts the parser
        if (last_char)
        begin
            phase_next = PH_NAME;
            dlen_next  = DEFAULT_LEN;
            doct_next  = DEFAULT_OCT;
            tempo_next = DEFAULT_BPM;
            tag_next   = TAG_NONE;
            acc_next   = 16'd0;
            tlen_next  = 16'd0;
            let_next   = 3'd0;
            sharp_next = 1'b0;
            toct_next  = 16'd0;
            dot_next   = 1'b0;
        end

        status.need_hdr  = end_hdr && !last_char;
        status.need_note = emit || last_note;
        status.need_bare = last_char && !emit && !last_note;
        status.div_busy  = (cnt_reg != '0);
        status.out_free  = !ov_reg || out_ready;
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME;
            dlen_reg  <= DEFAULT_LEN;
            doct_reg  <= DEFAULT_OCT;
            tempo_reg <= DEFAULT_BPM;
            whole_reg <= 18'd0;
            tag_reg   <= TAG_NONE;
            acc_reg   <= 16'd0;
            tlen_reg  <= 16'd0;
            let_reg   <= 3'd0;
            sharp_reg <= 1'b0;
            toct_reg  <= 16'd0;
            dot_reg   <= 1'b0;
            vol_reg   <= VOLUME_RESET;
        end
        else
        begin
            if (cfg_write)
                vol_reg <= volume_level;
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                dlen_reg  <= dlen_next;
                doct_reg  <= doct_next;
                tempo_reg <= tempo_next;
                tag_reg   <= tag_next;
                acc_reg   <= acc_next;
                tlen_reg  <= tlen_next;
                let_reg   <= let_next;
                sharp_reg <= sharp_next;
                toct_reg  <= toct_next;
                dot_reg   <= dot_next;
                if (last_char)
                    whole_reg <= 18'd0;
            end
            else if (cmd.hdr_write)
                whole_reg <= {quo_reg[15:0], 2'b00};
        end
    end

    // letter of the note being sent, after this beat's parse
    function automatic logic [2:0] cap_let_sel(input logic [2:0] cur, input logic [3:0] ph,
                                               input logic [7:0] c);
        logic [2:0] r;
        if (ph == PH_TOK_START || ph == PH_TOK_LEN)
            r = letter_code(c);
        else
            r = cur;
        return r;
    endfunction

    // note capture at the beat that sends it
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_let_reg   <= (phase_reg == PH_TOK_LETTER || phase_reg == PH_TOK_SHARP ||
                            phase_reg == PH_TOK_OCT || phase_reg == PH_TOK_SKIP ||
                            !emit) ? ((emit || last_note) ? cap_let_sel(let_reg, phase_reg,
                            char_code) : 3'd0) : 3'd0;
            p_sharp_reg <= emit ? sharp_reg : (sharp_reg || (phase_reg == PH_TOK_LETTER &&
                            char_code == 8'h23 && let_reg != 3'd0));
            p_dot_reg   <= emit ? dot_reg : (dot_reg || (after_let && char_code == 8'h2e));
            p_oct_reg   <= cap_oct;
            p_note_reg  <= emit || last_note;
            p_end_reg   <= last_char;
        end
    end

    // restoring divider, one quotient bit per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[17]};
        diff  = trial - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.accept && (status.need_hdr || status.need_note))
            cnt_reg <= CNT_W'(DIV_STEPS);
        else if (cnt_reg != '0)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rem_reg <= 16'd0;
            quo_reg <= status.need_hdr ? MS_PER_MINUTE : whole_reg;
            dvs_reg <= status.need_hdr ? tempo_next : cap_len;
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[16])
            begin
                rem_reg <= diff[15:0];
                quo_reg <= {quo_reg[16:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[16:0], 1'b0};
            end
        end
    end

    // result build
    logic [18:0] ms_raw;
    logic [3:0]  semi;
    logic [5:0]  tidx;
    logic        rest_c;

    always_comb
    begin
        ms_raw = {1'b0, quo_reg} + (p_dot_reg ? {2'b00, quo_reg[17:1]} : 19'd0);
        if (ms_raw < MIN_NOTE_MS)
            ms_raw = MIN_NOTE_MS;
        semi = semitone_of(p_let_reg);
        if (p_sharp_reg)
            semi = (semi == 4'd11) ? 4'd0 : semi + 4'd1;
        tidx   = ({4'd0, p_oct_reg} << 3) + ({4'd0, p_oct_reg} << 2) + {2'd0, semi};
        rest_c = (p_let_reg == 3'd0);
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            note_o_reg <= p_note_reg;
            end_o_reg  <= p_end_reg;
            if (p_note_reg)
            begin
                rest_o_reg <= rest_c;
                freq_o_reg <= rest_c ? 12'd0 : tone_of(tidx);
                ms_o_reg   <= ms_raw;
                duty_o_reg <= rest_c ? 8'd0 : duty_of(vol_reg);
            end
            else
            begin
                rest_o_reg <= 1'b0;
                freq_o_reg <= 12'd0;
                ms_o_reg   <= 19'd0;
                duty_o_reg <= 8'd0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign is_note      = note_o_reg;
    assign is_rest      = rest_o_reg;
    assign frequency_hz = freq_o_reg;
    assign duration_ms  = ms_o_reg;
    assign pwm_duty     = duty_o_reg;
    assign tune_end     = end_o_reg;

endmodule

>>> bench/rtttl_ringtone_note_parser_tb.sv
// rtttl_ringtone_note_parser_tb: self-checking bench for the ringtone note parser
// depends on rtttl_pkg and rtttl_ringtone_note_parser
module rtttl_ringtone_note_parser_tb;
    import rtttl_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_beat_t;

    typedef struct packed {
        logic        note;
        logic        rest;
        logic [11:0] freq;
        logic [18:0] dur;
        logic [7:0]  duty;
        logic        tend;
    } note_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_code;
    logic        last_char;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  volume_level;
    logic        out_valid;
    logic        out_ready;
    logic        is_note;
    logic        is_rest;
    logic [11:0] frequency_hz;
    logic [18:0] duration_ms;
    logic [7:0]  pwm_duty;
    logic        tune_end;

    char_beat_t   pending_chars[$];
    note_result_t expected_notes[$];
    int           fail_count;
    int           sent_count;
    int           send_gap;
    int           recv_gap;
    logic [3:0]   vol_steps[5] = '{4'd0, 4'd10, 4'd15, 4'd1, 4'd7};

    // predictor state
    logic [3:0]  p_vol;
    logic [3:0]  p_phase;
    logic [15:0] p_def_len;
    logic [2:0]  p_def_oct;
    logic [15:0] p_bpm;
    logic [17:0] p_whole;
    logic [1:0]  p_tag;
    logic [15:0] p_acc;
    logic [15:0] p_len;
    logic [2:0]  p_letter;
    logic        p_sharp;
    logic [15:0] p_oct;
    logic        p_dot;

    rtttl_ringtone_note_parser uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .last_char(last_char),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .volume_level(volume_level),
        .out_valid(out_valid), .out_ready(out_ready),
        .is_note(is_note), .is_rest(is_rest), .frequency_hz(frequency_hz),
        .duration_ms(duration_ms), .pwm_duty(pwm_duty), .tune_end(tune_end)
    );

    always #6 clk = ~clk;

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
    endfunction

    function automatic logic [2:0] pitch_code(logic [7:0] c);
        case (fold_case(c))
            "c": return 3'd1;
            "d": return 3'd2;
            "e": return 3'd3;
            "f": return 3'd4;
            "g": return 3'd5;
            "a": return 3'd6;
            "b", "h": return 3'd7;
            default: return 3'd0;
        endcase
    endfunction

    function automatic logic [11:0] tone_hz(int idx);
        int hz[48] = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
            523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
            1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
            2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951};
        return 12'(hz[idx]);
    endfunction

    task automatic clear_tok();
        p_len = 0; p_letter = 0; p_sharp = 0; p_oct = 0; p_dot = 0;
    endtask

    task automatic restart_tune();
        p_phase = PH_NAME; p_def_len = 4; p_def_oct = 6; p_bpm = 63;
        p_whole = 0; p_tag = TAG_NONE; p_acc = 0;
        clear_tok();
    endtask

    task automatic close_header();
        int bpm;
        bpm = (p_bpm != 0) ? p_bpm : 63;
        p_whole = 18'((60000 / bpm) * 4);
        p_phase = PH_TOK_START;
        clear_tok();
    endtask

    function automatic note_result_t build_note();
        note_result_t r;
        int len, oct, ms, semi, v;
        int dtab[10] = '{8, 21, 34, 48, 61, 74, 88, 101, 114, 128};
        int stab[8] = '{0, 0, 2, 4, 5, 7, 9, 11};
        len = (p_len != 0) ? p_len : p_def_len;
        oct = (p_oct != 0) ? p_oct : p_def_oct;
        if (len == 0) len = 1;
        ms = p_whole / len;
        if (p_dot) ms += ms / 2;
        if (ms < 10) ms = 10;
        r = '0;
        r.note = 1;
        r.rest = (p_letter == 0);
        r.dur = 19'(ms);
        if (p_letter != 0) begin
            semi = stab[p_letter];
            if (p_sharp) semi = (semi + 1) % 12;
            if (oct < 4) oct = 4;
            if (oct > 7) oct = 7;
            r.freq = tone_hz((oct - 4) * 12 + semi);
            v = (p_vol > 10) ? 10 : p_vol;
            r.duty = (v == 0) ? 8'd0 : 8'(dtab[v - 1]);
        end
        return r;
    endfunction

    // returns 1 if a note closed
    task automatic after_pitch(logic [7:0] c, output bit done, output note_result_t r);
        done = 0;
        if (is_dig(c)) begin
            p_oct = {12'd0, c[3:0]}; p_phase = PH_TOK_OCT;
        end else if (c == ".") begin
            p_dot = 1; p_phase = PH_TOK_SKIP;
        end else if (c == ",") begin
            r = build_note(); clear_tok(); p_phase = PH_TOK_START; done = 1;
        end else p_phase = PH_TOK_SKIP;
    endtask

    task automatic predict_char(char_beat_t b);
        logic [7:0]   c;
        bit           done;
        note_result_t r;
        c = b.code;
        done = 0;
        r = '0;
        case (p_phase)
            PH_NAME: if (c == ":") p_phase = PH_HDR_ITEM;
            PH_HDR_ITEM: begin
                if (c == ":") close_header();
                else if (c == " " || c == ",") ;
                else if (fold_case(c) == "d") begin p_tag = TAG_D; p_phase = PH_HDR_TAG; end
                else if (fold_case(c) == "o") begin p_tag = TAG_O; p_phase = PH_HDR_TAG; end
                else if (fold_case(c) == "b") begin p_tag = TAG_B; p_phase = PH_HDR_TAG; end
                else p_phase = PH_HDR_SKIP;
            end
            PH_HDR_TAG: begin
                if (c == "=") begin p_acc = 0; p_phase = PH_HDR_NUM; end
                else if (c == ":") close_header();
                else if (c == ",") p_phase = PH_HDR_ITEM;
                else p_phase = PH_HDR_SKIP;
            end
            PH_HDR_NUM: begin
                if (is_dig(c)) p_acc = 16'(p_acc * 10 + c[3:0]);
                else begin
                    if (p_tag == TAG_D && p_acc != 0) p_def_len = p_acc;
                    if (p_tag == TAG_O && p_acc >= 4 && p_acc <= 7) p_def_oct = p_acc[2:0];
                    if (p_tag == TAG_B && p_acc != 0) p_bpm = p_acc;
                    if (c == ":") close_header();
                    else if (c == ",") p_phase = PH_HDR_ITEM;
                    else p_phase = PH_HDR_SKIP;
                end
            end
            PH_HDR_SKIP: begin
                if (c == ":") close_header();
                else if (c == ",") p_phase = PH_HDR_ITEM;
            end
            PH_TOK_START: begin
                if (c == " " || c == ",") ;
                else if (is_dig(c)) begin p_len = {12'd0, c[3:0]}; p_phase = PH_TOK_LEN; end
                else begin p_letter = pitch_code(c); p_phase = PH_TOK_LETTER; end
            end
            PH_TOK_LEN: begin
                if (is_dig(c)) p_len = 16'(p_len * 10 + c[3:0]);
                else begin p_letter = pitch_code(c); p_phase = PH_TOK_LETTER; end
            end
            PH_TOK_LETTER: begin
                if (c == "#") begin
                    if (p_letter != 0) p_sharp = 1;
                    p_phase = PH_TOK_SHARP;
                end else after_pitch(c, done, r);
            end
            PH_TOK_SHARP: after_pitch(c, done, r);
            PH_TOK_OCT: begin
                if (is_dig(c)) p_oct = 16'(p_oct * 10 + c[3:0]);
                else after_pitch(c, done, r);
            end
            PH_TOK_SKIP: if (c == ",") begin
                r = build_note(); clear_tok(); p_phase = PH_TOK_START; done = 1;
            end
            default: p_phase = PH_NAME;
        endcase
        if (b.last) begin
            if (!done) begin
                if (p_phase >= PH_TOK_LETTER && p_phase <= PH_TOK_SKIP) r = build_note();
                else r = '0;
            end
            r.tend = 1;
            done = 1;
            restart_tune();
        end
        if (done) expected_notes.push_back(r);
    endtask

    // queue helpers for stimulus
    task automatic put_text(string s, bit close);
        char_beat_t b;
        for (int i = 0; i < s.len(); i++) begin
            b.code = s[i];
            b.last = close && (i == s.len() - 1);
            pending_chars.push_back(b);
        end
    endtask

    task automatic put_byte(logic [7:0] code, bit close);
        char_beat_t b;
        b.code = code;
        b.last = close;
        pending_chars.push_back(b);
    endtask

    function automatic string rand_note();
        string s, pool;
        pool = "cdefgabhpCDEFGABHPxz";
        s = "";
        if ($urandom_range(0, 2) == 0) s = $sformatf("%0d", $urandom_range(1, 32));
        if ($urandom_range(0, 40) == 0) s = "0";
        s = {s, string'(pool[$urandom_range(0, pool.len() - 1)])};
        if ($urandom_range(0, 3) == 0) s = {s, "#"};
        if ($urandom_range(0, 2) == 0) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 4) == 0) s = {s, "."};
        return {s, ","};
    endfunction

    function automatic string rand_header();
        string s;
        s = "tune:";
        if ($urandom_range(0, 1)) s = {s, $sformatf("d=%0d,", $urandom_range(0, 64))};
        if ($urandom_range(0, 1)) s = {s, $sformatf("O=%0d,", $urandom_range(0, 9))};
        if ($urandom_range(0, 1)) s = {s, $sformatf("b=%0d,", $urandom_range(0, 400))};
        if ($urandom_range(0, 5) == 0) s = {s, "x=3,"};
        return {s, ":"};
    endfunction

    // every queued byte taken and every predicted result checked
    task automatic run_chars();
        while (pending_chars.size() != 0 || in_valid || expected_notes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_volume(logic [3:0] v);
        cfg_valid <= 1'b1;
        volume_level <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        p_vol = v;
        cfg_valid <= 1'b0;
    endtask

    // input driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_char({char_code, last_char});
                sent_count <= sent_count + 1;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    {char_code, last_char} <= pending_chars.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= ($urandom_range(0, 3) == 0)
                        ? (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 3)) : 0;
                end else in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        note_result_t got, want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got = {is_note, is_rest, frequency_hz, duration_ms, pwm_duty, tune_end};
                if (expected_notes.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    want = expected_notes.pop_front();
                    if (got.note !== want.note) begin
                        $error("is_note exp %0d got %0d", want.note, got.note); fail_count++;
                    end
                    if (got.rest !== want.rest) begin
                        $error("is_rest exp %0d got %0d", want.rest, got.rest); fail_count++;
                    end
                    if (got.freq !== want.freq) begin
                        $error("frequency_hz exp %0d got %0d", want.freq, got.freq);
                        fail_count++;
                    end
                    if (got.dur !== want.dur) begin
                        $error("duration_ms exp %0d got %0d", want.dur, got.dur); fail_count++;
                    end
                    if (got.duty !== want.duty) begin
                        $error("pwm_duty exp %0d got %0d", want.duty, got.duty); fail_count++;
                    end
                    if (got.tend !== want.tend) begin
                        $error("tune_end exp %0d got %0d", want.tend, got.tend); fail_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                    recv_gap <= ($urandom_range(0, 12) == 0) ? $urandom_range(10, 50)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    initial begin
        clk = 0; rst_n = 0;
        in_valid = 0; char_code = 0; last_char = 0;
        cfg_valid = 0; volume_level = 0; out_ready = 0;
        fail_count = 0; sent_count = 0; send_gap = 0; recv_gap = 0;
        p_vol = VOLUME_RESET;
        restart_tune();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: defaults, tags, sharps, octave clamps, dots, rests, ends
        put_text("x:d=8,o=5,b=120:c,C#4.,b#7,e#,h,p#,32a9.,0g,4x,1f#12,", 0);
        put_text("n:B=0,d=0,o=9:a,", 0);
        put_text("t:b=65535:a,c,", 1);
        put_text("q:d=1:", 0);
        put_byte(8'h00, 0);
        put_byte(8'hff, 0);
        put_text(",2a", 1);
        put_text(":", 1);
        put_text({"z:b=", 8'h80, "5:8", 8'h7f}, 1);
        put_text("r:d=65536:d,", 1);
        run_chars();

        // random tunes across volume steps
        foreach (vol_steps[k]) begin
            write_volume(vol_steps[k]);
            repeat (2) begin
                string s;
                s = rand_header();
                repeat ($urandom_range(3, 8)) s = {s, rand_note()};
                put_text(s, 0);
                if ($urandom_range(0, 3) == 0) begin
                    char_beat_t b;
                    b.code = $urandom_range(0, 255);
                    b.last = $urandom_range(0, 1);
                    pending_chars.push_back(b);
                end
                if ($urandom_range(0, 1)) put_text("a", 1);
                else put_text(",", 1);
            end
            repeat (25) begin
                char_beat_t b;
                b.code = $urandom_range(0, 255);
                b.last = ($urandom_range(0, 30) == 0);
                pending_chars.push_back(b);
            end
            put_text(":", 1);
            run_chars();
        end

        if (fail_count == 0 && expected_notes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule
